FILE: rtl/core/string_io_exit_planner_macros.svh
// ----------------------------------------------------------------------------
// string io exit planner assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef STRING_IO_EXIT_PLANNER_MACROS_SVH
`define STRING_IO_EXIT_PLANNER_MACROS_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define SIOXP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define SIOXP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SIOXP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SIOXP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/core/sioxp_pkg.sv
// ----------------------------------------------------------------------------
// sioxp_pkg
// shared types, codes and width helpers of the string io exit planner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sioxp_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int BIT_IN     = 0;
  localparam int BIT_STR    = 2;
  localparam int BIT_REP    = 3;
  localparam int BIT_SZ8    = 4;
  localparam int BIT_SZ16   = 5;
  localparam int BIT_A16    = 7;
  localparam int BIT_A32    = 8;
  localparam int BIT_A64    = 9;
  localparam int PORT_LO    = 16;
  localparam int PORT_HI    = 31;

  localparam logic [63:0] MASK16 = 64'h0000_0000_0000_FFFF;
  localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MASK64 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NOT_STRING = 2'd1,
    STAT_OVERFLOW   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ASZ_16 = 2'd0,
    ASZ_32 = 2'd1,
    ASZ_64 = 2'd2
  } asz_t;

  // classified beat handed from front to back
  typedef struct packed {
    logic        not_str;
    logic        is_input;
    logic [15:0] port;
    logic [2:0]  ub;
    logic [1:0]  shift;
    asz_t        asz;
    logic        rep;
    logic        down;
    logic [63:0] idx;
    logic [63:0] idx_reg;
    logic [63:0] cnt;
    logic [63:0] ncnt;
    logic [63:0] start;
    logic [63:0] base;
  } plan_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [63:0] width_mask(asz_t asz);
    logic [63:0] m;
    case (asz)
      ASZ_16:  m = MASK16;
      ASZ_32:  m = MASK32;
      ASZ_64:  m = MASK64;
      default: m = MASK32;
    endcase
    return m;
  endfunction

  function automatic logic [63:0] write_back(logic [63:0] old, logic [63:0] val, asz_t asz);
    logic [63:0] r;
    case (asz)
      ASZ_64:  r = val;
      ASZ_32:  r = val & MASK32;
      ASZ_16:  r = (old & ~MASK16) | (val & MASK16);
      default: r = val & MASK32;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/sioxp_front.sv
// ----------------------------------------------------------------------------
// sioxp_front
// takes command beats, decodes the exit word and masks index and count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sioxp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [63:0]          in_exit_info,
  input  logic [63:0]          in_index_reg,
  input  logic [63:0]          in_count_reg,
  input  logic [63:0]          in_seg_base,
  input  logic                 in_direction_flag,
  input  logic                 q_can_push,
  output logic                 push,
  output sioxp_pkg::plan_req_t push_data
);
  import sioxp_pkg::*;

  logic      valid_r, valid_nxt;
  plan_req_t req_r, req_nxt;
  logic      accept;
  asz_t      asz;
  logic [63:0] m;

  assign busy   = valid_r && !q_can_push;
  assign accept = start && !busy;
  assign push   = valid_r && q_can_push;
  assign push_data = req_r;

  always_comb begin
    if (in_exit_info[BIT_A16]) begin
      asz = ASZ_16;
    end else if (in_exit_info[BIT_A32]) begin
      asz = ASZ_32;
    end else if (in_exit_info[BIT_A64]) begin
      asz = ASZ_64;
    end else begin
      asz = ASZ_32;
    end
    m = width_mask(asz);

    req_nxt.not_str  = !in_exit_info[BIT_STR];
    req_nxt.is_input = in_exit_info[BIT_IN];
    req_nxt.port     = in_exit_info[PORT_HI:PORT_LO];
    if (in_exit_info[BIT_SZ8]) begin
      req_nxt.ub    = 3'd1;
      req_nxt.shift = 2'd0;
    end else if (in_exit_info[BIT_SZ16]) begin
      req_nxt.ub    = 3'd2;
      req_nxt.shift = 2'd1;
    end else begin
      req_nxt.ub    = 3'd4;
      req_nxt.shift = 2'd2;
    end
    req_nxt.asz     = asz;
    req_nxt.rep     = in_exit_info[BIT_REP];
    req_nxt.down    = in_direction_flag;
    req_nxt.idx     = in_index_reg & m;
    req_nxt.idx_reg = in_index_reg;
    req_nxt.cnt     = in_exit_info[BIT_REP] ? (in_count_reg & m) : 64'd1;
    req_nxt.ncnt    = in_exit_info[BIT_REP] ? write_back(in_count_reg, 64'd0, asz)
                                            : in_count_reg;
    req_nxt.start   = in_seg_base + (in_index_reg & m);
    req_nxt.base    = in_seg_base;
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= req_nxt;
    end
  end

endmodule

FILE: rtl/core/sioxp_queue.sv
// ----------------------------------------------------------------------------
// sioxp_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sioxp_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sioxp_pkg::plan_req_t push_data,
  input  logic                 pop,
  output sioxp_pkg::plan_req_t pop_data,
  output sioxp_pkg::q_stat_t   stat
);
  import sioxp_pkg::*;

  plan_req_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/sioxp_back.sv
// ----------------------------------------------------------------------------
// sioxp_back
// two stage plan unit: range checks, then addresses, write back and result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sioxp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  sioxp_pkg::plan_req_t req,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic                 out_is_input,
  output logic [15:0]          out_port_number,
  output logic [2:0]           out_unit_size,
  output logic [63:0]          out_unit_count,
  output logic                 out_descending,
  output logic [63:0]          out_start_addr,
  output logic [63:0]          out_lowest_addr,
  output logic [63:0]          out_byte_total,
  output logic [63:0]          out_index_after,
  output logic [63:0]          out_count_after,
  output logic                 out_is_repeat
);
  import sioxp_pkg::*;

  // stage one
  logic        cnt_zero, ovf_mul;
  logic [63:0] bytes, span, nval;
  logic [64:0] diff_w, sum_w;
  logic        err;

  plan_req_t   m_req_r;
  logic        m_valid_r;
  logic        m_zero_r, m_err_r;
  logic [63:0] m_bytes_r, m_diff_r, m_nval_r;

  // stage two
  logic [63:0] low, nidx;
  logic        valid_r;
  status_t     status_r, status_nxt;
  logic        is_input_r, is_input_nxt;
  logic [15:0] port_r, port_nxt;
  logic [2:0]  ub_r, ub_nxt;
  logic [63:0] cnt_r, cnt_nxt;
  logic        down_r, down_nxt;
  logic [63:0] start_r, start_nxt;
  logic [63:0] low_r, low_nxt;
  logic [63:0] bytes_r, bytes_nxt;
  logic [63:0] nidx_r, nidx_nxt;
  logic [63:0] ncnt_r, ncnt_nxt;
  logic        rep_r, rep_nxt;

  always_comb begin
    cnt_zero = (req.cnt == 64'd0);
    case (req.shift)
      2'd1:    ovf_mul = req.cnt[63];
      2'd2:    ovf_mul = (req.cnt[63:62] != 2'b00);
      default: ovf_mul = 1'b0;
    endcase
    bytes  = req.cnt << req.shift;
    span   = bytes - {61'd0, req.ub};
    diff_w = {1'b0, req.idx} - {1'b0, span};
    sum_w  = {1'b0, req.start} + {1'b0, bytes};
    nval   = req.down ? (req.idx - bytes) : (req.idx + bytes);
    err    = !cnt_zero && (ovf_mul || (req.down ? diff_w[64] : sum_w[64]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      m_req_r   <= req;
      m_zero_r  <= cnt_zero;
      m_err_r   <= err;
      m_bytes_r <= cnt_zero ? 64'd0 : bytes;
      m_diff_r  <= diff_w[63:0];
      m_nval_r  <= nval;
    end
  end

  always_comb begin
    low  = (m_zero_r || !m_req_r.down) ? m_req_r.start : (m_req_r.base + m_diff_r);
    nidx = m_zero_r ? m_req_r.idx_reg : write_back(m_req_r.idx_reg, m_nval_r, m_req_r.asz);

    status_nxt   = STAT_OK;
    is_input_nxt = 1'b0;
    port_nxt     = '0;
    ub_nxt       = '0;
    cnt_nxt      = '0;
    down_nxt     = 1'b0;
    start_nxt    = '0;
    low_nxt      = '0;
    bytes_nxt    = '0;
    nidx_nxt     = '0;
    ncnt_nxt     = '0;
    rep_nxt      = 1'b0;
    if (m_req_r.not_str) begin
      status_nxt = STAT_NOT_STRING;
    end else if (m_err_r) begin
      status_nxt = STAT_OVERFLOW;
    end else begin
      is_input_nxt = m_req_r.is_input;
      port_nxt     = m_req_r.port;
      ub_nxt       = m_req_r.ub;
      cnt_nxt      = m_req_r.cnt;
      down_nxt     = m_req_r.down;
      start_nxt    = m_req_r.start;
      low_nxt      = low;
      bytes_nxt    = m_bytes_r;
      nidx_nxt     = nidx;
      ncnt_nxt     = m_req_r.ncnt;
      rep_nxt      = m_req_r.rep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m_valid_r) begin
      status_r   <= status_nxt;
      is_input_r <= is_input_nxt;
      port_r     <= port_nxt;
      ub_r       <= ub_nxt;
      cnt_r      <= cnt_nxt;
      down_r     <= down_nxt;
      start_r    <= start_nxt;
      low_r      <= low_nxt;
      bytes_r    <= bytes_nxt;
      nidx_r     <= nidx_nxt;
      ncnt_r     <= ncnt_nxt;
      rep_r      <= rep_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_is_input    = is_input_r;
  assign out_port_number = port_r;
  assign out_unit_size   = ub_r;
  assign out_unit_count  = cnt_r;
  assign out_descending  = down_r;
  assign out_start_addr  = start_r;
  assign out_lowest_addr = low_r;
  assign out_byte_total  = bytes_r;
  assign out_index_after = nidx_r;
  assign out_count_after = ncnt_r;
  assign out_is_repeat   = rep_r;

endmodule

FILE: rtl/core/string_io_exit_planner.sv
// ----------------------------------------------------------------------------
// string_io_exit_planner
// decodes an io exit word and plans the string transfer it asks for
// path: a taken beat goes through the front register, the queue, then the stage one and stage two registers
// throughput: one beat per cycle; the back end never stalls, so busy stays low
// in steady use; busy only rises if the two entry queue is full
// reset: synchronous active low rst_n clears all valid flags and queue pointers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "string_io_exit_planner_macros.svh"

module string_io_exit_planner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_exit_info,
  input  logic [63:0] in_index_reg,
  input  logic [63:0] in_count_reg,
  input  logic [63:0] in_seg_base,
  input  logic        in_direction_flag,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic        out_is_input,
  output logic [15:0] out_port_number,
  output logic [2:0]  out_unit_size,
  output logic [63:0] out_unit_count,
  output logic        out_descending,
  output logic [63:0] out_start_addr,
  output logic [63:0] out_lowest_addr,
  output logic [63:0] out_byte_total,
  output logic [63:0] out_index_after,
  output logic [63:0] out_count_after,
  output logic        out_is_repeat
);
  import sioxp_pkg::*;

  logic      push;
  plan_req_t push_data;
  plan_req_t pop_data;
  q_stat_t   q_stat;
  logic      pop;

  assign pop = !q_stat.empty;

  sioxp_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_exit_info      (in_exit_info),
    .in_index_reg      (in_index_reg),
    .in_count_reg      (in_count_reg),
    .in_seg_base       (in_seg_base),
    .in_direction_flag (in_direction_flag),
    .q_can_push        (!q_stat.full),
    .push              (push),
    .push_data         (push_data)
  );

  sioxp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  sioxp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (pop),
    .req             (pop_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_is_input    (out_is_input),
    .out_port_number (out_port_number),
    .out_unit_size   (out_unit_size),
    .out_unit_count  (out_unit_count),
    .out_descending  (out_descending),
    .out_start_addr  (out_start_addr),
    .out_lowest_addr (out_lowest_addr),
    .out_byte_total  (out_byte_total),
    .out_index_after (out_index_after),
    .out_count_after (out_count_after),
    .out_is_repeat   (out_is_repeat)
  );

  `SIOXP_ASSERT_IMP(a_q_full_empty, clk, rst_n, 1'b1, !(q_stat.full && q_stat.empty))
  `SIOXP_ASSERT_IMP(a_busy_needs_full, clk, rst_n, busy, q_stat.full)
  `SIOXP_ASSERT_NXT(a_pop_gives_beat, clk, rst_n, pop, ##1 out_valid)
  `SIOXP_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && (out_status != STAT_OK),
                    (out_unit_size == 3'd0) && (out_start_addr == 64'd0) && !out_is_repeat)
  `SIOXP_ASSERT_IMP(a_ok_unit, clk, rst_n, out_valid && (out_status == STAT_OK),
                    (out_unit_size == 3'd1) || (out_unit_size == 3'd2) ||
                    (out_unit_size == 3'd4))

endmodule

FILE: tb/exit_plan_checker.sv
// ----------------------------------------------------------------------------
// exit_plan_checker
// watches the command and result channels of the string io exit planner,
// predicts the transfer plan of every accepted beat and compares each result
// beat field by field with the oldest plan still waiting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module exit_plan_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_exit_info,
  input  logic [63:0] in_index_reg,
  input  logic [63:0] in_count_reg,
  input  logic [63:0] in_seg_base,
  input  logic        in_direction_flag,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic        out_is_input,
  input  logic [15:0] out_port_number,
  input  logic [2:0]  out_unit_size,
  input  logic [63:0] out_unit_count,
  input  logic        out_descending,
  input  logic [63:0] out_start_addr,
  input  logic [63:0] out_lowest_addr,
  input  logic [63:0] out_byte_total,
  input  logic [63:0] out_index_after,
  input  logic [63:0] out_count_after,
  input  logic        out_is_repeat,
  output int unsigned fail_count,
  output int unsigned pending
);
  import sioxp_pkg::*;

  typedef struct packed {
    status_t     status;
    logic        is_input;
    logic [15:0] port;
    logic [2:0]  unit_size;
    logic [63:0] unit_count;
    logic        descending;
    logic [63:0] start_addr;
    logic [63:0] lowest_addr;
    logic [63:0] byte_total;
    logic [63:0] index_after;
    logic [63:0] count_after;
    logic        is_repeat;
  } plan_t;

  plan_t       plan_q[$];
  plan_t       want_plan;
  logic [63:0] want [12];
  logic [63:0] got  [12];
  int unsigned errs = 0;
  string       fld_name [12] = '{"status", "is_input", "port_number", "unit_size",
                                 "unit_count", "descending", "start_addr", "lowest_addr",
                                 "byte_total", "index_after", "count_after", "is_repeat"};

  // x86 register write rules per address width
  function automatic logic [63:0] merge_width(logic [63:0] old, logic [63:0] val, asz_t asz);
    case (asz)
      ASZ_64:  return val;
      ASZ_16:  return {old[63:16], val[15:0]};
      default: return {32'd0, val[31:0]};
    endcase
  endfunction

  function automatic plan_t predict_plan(logic [63:0] w, logic [63:0] idx_reg,
                                         logic [63:0] cnt_reg, logic [63:0] base,
                                         logic down);
    plan_t       p;
    logic [2:0]  ub;
    asz_t        asz;
    logic [63:0] m;
    logic [63:0] idx;
    logic [63:0] cnt;
    logic [63:0] first;
    logic [65:0] prod;
    logic [64:0] reach;
    logic [63:0] span;
    p = '0;
    if (!w[BIT_STR]) begin
      p.status = STAT_NOT_STRING;
      return p;
    end
    ub  = w[BIT_SZ8] ? 3'd1 : (w[BIT_SZ16] ? 3'd2 : 3'd4);
    asz = w[BIT_A16] ? ASZ_16 : (w[BIT_A32] ? ASZ_32 : (w[BIT_A64] ? ASZ_64 : ASZ_32));
    m   = (asz == ASZ_64) ? MASK64 : ((asz == ASZ_32) ? MASK32 : MASK16);
    idx   = idx_reg & m;
    cnt   = w[BIT_REP] ? (cnt_reg & m) : 64'd1;
    first = base + idx;
    p.status      = STAT_OK;
    p.is_input    = w[BIT_IN];
    p.port        = w[PORT_HI:PORT_LO];
    p.unit_size   = ub;
    p.unit_count  = cnt;
    p.descending  = down;
    p.start_addr  = first;
    p.is_repeat   = w[BIT_REP];
    p.count_after = w[BIT_REP] ? merge_width(cnt_reg, 64'd0, asz) : cnt_reg;
    if (cnt == 64'd0) begin
      p.byte_total  = 64'd0;
      p.lowest_addr = first;
      p.index_after = idx_reg;
      return p;
    end
    prod = {2'b00, cnt} * {63'd0, ub};
    if (prod[65:64] != 2'b00) begin
      p = '0;
      p.status = STAT_OVERFLOW;
      return p;
    end
    p.byte_total = prod[63:0];
    span = prod[63:0] - {61'd0, ub};
    if (down) begin
      if (idx < span) begin
        p = '0;
        p.status = STAT_OVERFLOW;
        return p;
      end
      p.lowest_addr = base + (idx - span);
      p.index_after = merge_width(idx_reg, idx - prod[63:0], asz);
    end else begin
      reach = {1'b0, first} + {1'b0, prod[63:0]};
      if (reach[64]) begin
        p = '0;
        p.status = STAT_OVERFLOW;
        return p;
      end
      p.lowest_addr = first;
      p.index_after = merge_width(idx_reg, idx + prod[63:0], asz);
    end
    return p;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (plan_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("[%0t] result beat with no plan waiting, status %0d", $realtime,
                     out_status);
        end else begin
          want_plan = plan_q.pop_front();
          want = '{64'(want_plan.status), 64'(want_plan.is_input), 64'(want_plan.port),
                   64'(want_plan.unit_size), want_plan.unit_count,
                   64'(want_plan.descending), want_plan.start_addr, want_plan.lowest_addr,
                   want_plan.byte_total, want_plan.index_after, want_plan.count_after,
                   64'(want_plan.is_repeat)};
          got  = '{64'(out_status), 64'(out_is_input), 64'(out_port_number),
                   64'(out_unit_size), out_unit_count, 64'(out_descending),
                   out_start_addr, out_lowest_addr, out_byte_total, out_index_after,
                   out_count_after, 64'(out_is_repeat)};
          for (int i = 0; i < 12; i++) begin
            if (got[i] !== want[i]) begin
              errs++;
              if (errs <= 10)
                $display("[%0t] %s mismatch: expected %h got %h", $realtime, fld_name[i],
                         want[i], got[i]);
            end
          end
        end
      end
      if (start && !busy)
        plan_q.push_back(predict_plan(in_exit_info, in_index_reg, in_count_reg, in_seg_base,
                                      in_direction_flag));
    end
    fail_count <= errs;
    pending    <= unsigned'(plan_q.size());
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives exit words into the string io exit planner: a directed set of
// corner cases, then random beats with bursts of idle cycles; the checker
// beside the block predicts and compares, this module gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import sioxp_pkg::*;

  localparam logic [2:0] SEL_NONE = 3'b000;
  localparam logic [2:0] SEL_A16  = 3'b001;
  localparam logic [2:0] SEL_A32  = 3'b010;
  localparam logic [2:0] SEL_A64  = 3'b100;
  localparam int         N_RAND   = 1800;
  localparam int         N_CALM   = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_exit_info = '0;
  logic [63:0] in_index_reg = '0;
  logic [63:0] in_count_reg = '0;
  logic [63:0] in_seg_base = '0;
  logic        in_direction_flag = 1'b0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic        out_is_input;
  logic [15:0] out_port_number;
  logic [2:0]  out_unit_size;
  logic [63:0] out_unit_count;
  logic        out_descending;
  logic [63:0] out_start_addr;
  logic [63:0] out_lowest_addr;
  logic [63:0] out_byte_total;
  logic [63:0] out_index_after;
  logic [63:0] out_count_after;
  logic        out_is_repeat;
  int unsigned fail_count;
  int unsigned pending;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  string_io_exit_planner u_top (.*);

  exit_plan_checker u_chk (.*);

  function automatic logic [63:0] mk_exit(logic str, logic rep, logic sz8, logic sz16,
                                          logic [2:0] asel, logic dir_in, logic [15:0] port);
    logic [63:0] w;
    w = '0;
    w[BIT_IN]            = dir_in;
    w[BIT_STR]           = str;
    w[BIT_REP]           = rep;
    w[BIT_SZ8]           = sz8;
    w[BIT_SZ16]          = sz16;
    w[BIT_A16]           = asel[0];
    w[BIT_A32]           = asel[1];
    w[BIT_A64]           = asel[2];
    w[PORT_HI:PORT_LO]   = port;
    return w;
  endfunction

  // values clustered on the width boundaries, plus plain random ones
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [63:0] near;
    v    = {$urandom, $urandom};
    near = 64'($urandom_range(0, 40));
    case ($urandom_range(0, 7))
      2:       v = near;
      3:       v = 64'h0000_0000_0000_FFFF - near;
      4:       v = 64'h0000_0000_FFFF_FFFF - near;
      5:       v = 64'hFFFF_FFFF_FFFF_FFFF - near;
      6:       v[15:0] = near[15:0];
      7:       v[31:0] = near[31:0];
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_beat(logic [63:0] w, logic [63:0] idx, logic [63:0] cnt,
                           logic [63:0] base, logic df);
    @(negedge clk);
    in_exit_info      <= w;
    in_index_reg      <= idx;
    in_count_reg      <= cnt;
    in_seg_base       <= base;
    in_direction_flag <= df;
    start             <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    logic [63:0] w;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // not a string op, all zero and all ones around the string bit
    send_beat('0, '0, '0, '0, 1'b0);
    send_beat(~(64'd1 << BIT_STR), '1, '1, '1, 1'b1);
    send_beat('1, '1, '1, '1, 1'b1);
    send_beat(mk_exit(1'b1, 1'b0, 1'b0, 1'b0, SEL_NONE, 1'b0, 16'h0000), '0, '0, '0, 1'b0);
    // zero count
    send_beat(mk_exit(1'b1, 1'b1, 1'b1, 1'b0, SEL_A32, 1'b1, 16'h0080), 64'h1000, 64'h0,
              64'h2000, 1'b0);
    send_beat(mk_exit(1'b1, 1'b1, 1'b0, 1'b1, SEL_A16, 1'b0, 16'h03F8),
              64'hDEAD_BEEF_0000_0010, 64'hABCD_0000, 64'h10, 1'b1);
    // byte total overflow and its edge
    send_beat(mk_exit(1'b1, 1'b1, 1'b0, 1'b1, SEL_A64, 1'b0, 16'h0060), 64'h100, '1, '0,
              1'b0);
    send_beat(mk_exit(1'b1, 1'b1, 1'b0, 1'b0, SEL_A64, 1'b1, 16'h0061), '0,
              64'h4000_0000_0000_0000, '0, 1'b0);
    send_beat(mk_exit(1'b1, 1'b1, 1'b0, 1'b0, SEL_A64, 1'b1, 16'h0062), '0,
              64'h3FFF_FFFF_FFFF_FFFF, '0, 1'b0);
    // descending underflow and exact fit
    send_beat(mk_exit(1'b1, 1'b1, 1'b1, 1'b0, SEL_A32, 1'b0, 16'h1F0), 64'h2, 64'h5,
              64'h1000, 1'b1);
    send_beat(mk_exit(1'b1, 1'b1, 1'b0, 1'b1, SEL_A32, 1'b1, 16'h1F1), 64'h8, 64'h5,
              64'h1000, 1'b1);
    send_beat(mk_exit(1'b1, 1'b1, 1'b0, 1'b0, SEL_A64, 1'b0, 16'h1F2), 64'h3, 64'h2,
              64'h40, 1'b1);
    // ascending start address wrap without error, and exact fit at the top
    send_beat(mk_exit(1'b1, 1'b0, 1'b0, 1'b0, SEL_A64, 1'b0, 16'h2F8), 64'h1, 64'h77, '1,
              1'b0);
    send_beat(mk_exit(1'b1, 1'b0, 1'b0, 1'b0, SEL_A64, 1'b0, 16'h2F9), '0, 64'h77,
              64'hFFFF_FFFF_FFFF_FFFB, 1'b0);
    // address wrap without error
    send_beat(mk_exit(1'b1, 1'b1, 1'b1, 1'b0, SEL_A32, 1'b1, 16'h3F8), 64'h20, 64'h3,
              64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
    // width rules on write back
    send_beat(mk_exit(1'b1, 1'b1, 1'b0, 1'b1, SEL_A16, 1'b0, 16'h0CF8),
              64'h1234_5678_9ABC_FFFE, 64'h5555_0002, '0, 1'b0);
    send_beat(mk_exit(1'b1, 1'b1, 1'b0, 1'b0, SEL_A32, 1'b1, 16'h0CFC),
              64'hFFFF_0000_0000_0100, 64'hFFFF_FFFF_0000_0004, 64'h8000, 1'b1);
    send_beat(mk_exit(1'b1, 1'b0, 1'b0, 1'b0, SEL_A64, 1'b0, 16'h0CFD), '0, 64'h9, 64'h10,
              1'b1);
    // address size priority
    send_beat(mk_exit(1'b1, 1'b1, 1'b1, 1'b0, SEL_A32 | SEL_A64, 1'b0, 16'h0070),
              64'hFFFF_FFFF_0000_0010, 64'h1_0000_0004, '0, 1'b0);
    send_beat(mk_exit(1'b1, 1'b1, 1'b1, 1'b1, SEL_A16 | SEL_A64, 1'b1, 16'h0071),
              64'h1_0000_0010, 64'h1_0000_0004, '0, 1'b1);
    send_beat(mk_exit(1'b1, 1'b1, 1'b0, 1'b1, SEL_NONE, 1'b0, 16'h0072), 64'h1_0000_0010,
              64'h1_0000_0004, '0, 1'b0);
    send_beat(mk_exit(1'b1, 1'b0, 1'b0, 1'b1, SEL_A16, 1'b1, 16'hFFFF), 64'h7, 64'h0,
              64'h100, 1'b0);

    for (int i = 0; i < N_RAND; i++) begin
      if (i < N_RAND - N_CALM && $urandom_range(0, 5) == 0)
        idle_gap($urandom_range(1, 18));
      w = {$urandom, $urandom};
      w[BIT_STR] = ($urandom_range(0, 9) != 0);
      w[BIT_REP] = ($urandom_range(0, 3) != 0);
      send_beat(w, pick_value(), pick_value(), pick_value(), 1'($urandom_range(0, 1)));
    end
    @(negedge clk);
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("string_io_exit_planner verification clean");
    else
      $display("string_io_exit_planner verification failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("string_io_exit_planner verification failed");
    $finish;
  end

endmodule
